>>> rtl/ttmc_pkg.sv
// Shared constants and types for the touch trimmed-mean calibration block.
`timescale 1ns / 1ps
package ttmc_pkg;

   localparam int CNT_W             = 4;
   localparam int SUM_GROWTH        = 4;
   localparam int TRIM_SHIFT        = 3;
   localparam int DISP_W            = 16;
   localparam int CSR_W             = 32;
   localparam int NUM_REGS          = 6;
   localparam int REG_IDX_W         = 3;

   localparam logic [CNT_W-1:0] SAMPLES_PER_POINT = 4'd10;

   localparam logic [REG_IDX_W-1:0] REG_GAIN_X_FROM_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_X_FROM_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_X      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_Y_FROM_X = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_Y_FROM_Y = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;

   // Factory calibration in Q16.16.
   localparam logic signed [CSR_W-1:0] RST_GAIN_X_FROM_X = 32'sd5633;
   localparam logic signed [CSR_W-1:0] RST_GAIN_X_FROM_Y = -32'sd70;
   localparam logic signed [CSR_W-1:0] RST_OFFSET_X      = -32'sd326327;
   localparam logic signed [CSR_W-1:0] RST_GAIN_Y_FROM_X = -32'sd115;
   localparam logic signed [CSR_W-1:0] RST_GAIN_Y_FROM_Y = 32'sd4271;
   localparam logic signed [CSR_W-1:0] RST_OFFSET_Y      = -32'sd872862;

   typedef struct packed {
      logic load_prod;
      logic load_out;
      logic touched;
   } ttmc_ctl_type;

endpackage

>>> rtl/ttmc_calib.sv
// One axis of the affine calibration: registered products, then sum, truncate and saturate.
`timescale 1ns / 1ps
module ttmc_calib
   import ttmc_pkg::*;
#(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  ttmc_ctl_type               ctl,
   input  logic signed [CSR_W-1:0]    gain_a,
   input  logic signed [CSR_W-1:0]    gain_b,
   input  logic signed [CSR_W-1:0]    offset,
   input  logic        [ADC_BITS-1:0] avg_a,
   input  logic        [ADC_BITS-1:0] avg_b,
   output logic signed [DISP_W-1:0]   disp
);

   localparam int PW = CSR_W + ADC_BITS + 1;
   localparam int AW = PW + 2;
   localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
   localparam logic signed [AW-1:0] SAT_MIN = -(AW'(32768));

   logic signed [PW-1:0]     prod_a_ff;
   logic signed [PW-1:0]     prod_b_ff;
   logic signed [PW-1:0]     prod_a_in;
   logic signed [PW-1:0]     prod_b_in;
   logic signed [CSR_W-1:0]  offset_ff;
   logic signed [AW-1:0]     acc;
   logic signed [AW-1:0]     quot;
   logic signed [AW-1:0]     quot_t;
   logic                     round_up;
   logic signed [DISP_W-1:0] disp_in;
   logic signed [DISP_W-1:0] disp_ff;

   assign prod_a_in = PW'(gain_a) * PW'($signed({1'b0, avg_a}));
   assign prod_b_in = PW'(gain_b) * PW'($signed({1'b0, avg_b}));

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         offset_ff <= offset;
      end
      if (ctl.load_out) begin
         disp_ff <= disp_in;
      end
   end

   // Division by the fixed-point scale rounds toward zero.
   always_comb begin
      acc      = AW'(prod_a_ff) + AW'(prod_b_ff) + AW'(offset_ff);
      quot     = acc >>> FRAC_BITS;
      round_up = acc[AW-1] && (|acc[FRAC_BITS-1:0]);
      quot_t   = quot + AW'({1'b0, round_up});
      if (!ctl.touched) begin
         disp_in = '0;
      end else if (quot_t > SAT_MAX) begin
         disp_in = DISP_W'(SAT_MAX);
      end else if (quot_t < SAT_MIN) begin
         disp_in = DISP_W'(SAT_MIN);
      end else begin
         disp_in = quot_t[DISP_W-1:0];
      end
   end

   assign disp = disp_ff;

endmodule

>>> rtl/touch_trimmed_mean_calibrate_top.sv
// Top level of the touch trimmed-mean sampler with affine calibration.
//
// Each word on the req_ channel is one raw X/Y sample pair plus the pen level seen
// after it. The tenth sample of a set yields a touched result: the sums less the
// minimum and maximum of each axis, shifted right by 3, then mapped through the
// signed fixed-point affine calibration, truncated toward zero and saturated to
// 16 bits. A pen lift before the tenth sample yields an untouched word of zeros.
// Other samples yield no word.
// A sample is taken in every cycle in which req_tready is high. A result word reaches
// rsp_ through the three registers of the path, in order: the trimmed-average
// registers, the product registers and the output register.
// The calibration registers are written through csr_, which is always ready; the user
// must write them only while no sample is in flight. The block itself does not enforce this.
// Reset clears the running set and the pipeline and restores the factory
// calibration. When rsp_tready is low, results wait in the pipeline; req_tready
// falls only once every stage holds a word.
`timescale 1ns / 1ps
module touch_trimmed_mean_calibrate_top
   import ttmc_pkg::*;
#(
   parameter int ADC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // raw_x, raw_y, pen_down, zero fill
   input  logic [((2*ADC_BITS+1+7)/8)*8-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // avg_x, avg_y, disp_x, disp_y, zero fill
   output logic [((2*ADC_BITS+2*16+7)/8)*8-1:0] rsp_tdata,
   // touched
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [REG_IDX_W-1:0]                csr_index,
   input  logic [CSR_W-1:0]                    csr_data
);

   localparam int SW    = ADC_BITS + SUM_GROWTH;
   localparam int IN_W  = ((2*ADC_BITS+1+7)/8)*8;
   localparam int OUT_W = ((2*ADC_BITS+2*DISP_W+7)/8)*8;
   localparam int PAY_W = 2*ADC_BITS + 2*DISP_W;

   logic signed [CSR_W-1:0] regs_ff [NUM_REGS];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SW-1:0]       sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [ADC_BITS-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic [ADC_BITS-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;

   logic [ADC_BITS-1:0] raw_x, raw_y;
   logic                pen_down;
   logic                accept, first, full, emit;
   logic [SW-1:0]       trim_x, trim_y;

   logic                s1_valid_ff, s1_touched_ff;
   logic [ADC_BITS-1:0] s1_avg_x_ff, s1_avg_y_ff;
   logic                s2_valid_ff, s2_touched_ff;
   logic [ADC_BITS-1:0] s2_avg_x_ff, s2_avg_y_ff;
   logic                out_valid_ff, out_touched_ff;
   logic [ADC_BITS-1:0] out_avg_x_ff, out_avg_y_ff;

   logic                out_ready, s2_ready, s1_ready, load_s2, load_out;
   ttmc_ctl_type        ctl_x, ctl_y;
   logic signed [DISP_W-1:0] disp_x, disp_y;

   assign raw_x    = req_tdata[ADC_BITS-1:0];
   assign raw_y    = req_tdata[2*ADC_BITS-1:ADC_BITS];
   assign pen_down = req_tdata[2*ADC_BITS];

   // Handshake chain: a stage takes a word when it is empty or its word moves on.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign load_s2    = s1_valid_ff && s2_ready;
   assign load_out   = s2_valid_ff && out_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;
   assign csr_ready  = 1'b1;

   // Running statistics of the set, including the sample now offered.
   always_comb begin
      first    = (count_ff == '0);
      count_in = count_ff + 1'b1;
      sum_x_in = sum_x_ff + SW'(raw_x);
      sum_y_in = sum_y_ff + SW'(raw_y);
      min_x_in = (first || raw_x < min_x_ff) ? raw_x : min_x_ff;
      max_x_in = (first || raw_x > max_x_ff) ? raw_x : max_x_ff;
      min_y_in = (first || raw_y < min_y_ff) ? raw_y : min_y_ff;
      max_y_in = (first || raw_y > max_y_ff) ? raw_y : max_y_ff;
      full     = (count_in == SAMPLES_PER_POINT);
      emit     = full || !pen_down;
      trim_x   = sum_x_in - SW'(min_x_in) - SW'(max_x_in);
      trim_y   = sum_y_in - SW'(min_y_in) - SW'(max_y_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else if (accept) begin
         if (emit) begin
            count_ff <= '0;
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            min_x_ff <= '0;
            max_x_ff <= '0;
            min_y_ff <= '0;
            max_y_ff <= '0;
         end else begin
            count_ff <= count_in;
            sum_x_ff <= sum_x_in;
            sum_y_ff <= sum_y_in;
            min_x_ff <= min_x_in;
            max_x_ff <= max_x_in;
            min_y_ff <= min_y_in;
            max_y_ff <= max_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_GAIN_X_FROM_X] <= RST_GAIN_X_FROM_X;
         regs_ff[REG_GAIN_X_FROM_Y] <= RST_GAIN_X_FROM_Y;
         regs_ff[REG_OFFSET_X]      <= RST_OFFSET_X;
         regs_ff[REG_GAIN_Y_FROM_X] <= RST_GAIN_Y_FROM_X;
         regs_ff[REG_GAIN_Y_FROM_Y] <= RST_GAIN_Y_FROM_Y;
         regs_ff[REG_OFFSET_Y]      <= RST_OFFSET_Y;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAIN_X_FROM_X: regs_ff[REG_GAIN_X_FROM_X] <= csr_data;
            REG_GAIN_X_FROM_Y: regs_ff[REG_GAIN_X_FROM_Y] <= csr_data;
            REG_OFFSET_X:      regs_ff[REG_OFFSET_X]      <= csr_data;
            REG_GAIN_Y_FROM_X: regs_ff[REG_GAIN_Y_FROM_X] <= csr_data;
            REG_GAIN_Y_FROM_Y: regs_ff[REG_GAIN_Y_FROM_Y] <= csr_data;
            REG_OFFSET_Y:      regs_ff[REG_OFFSET_Y]      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept && emit) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_ready) begin
            s1_valid_ff <= 1'b0;
         end
         if (load_s2) begin
            s2_valid_ff <= 1'b1;
         end else if (out_ready) begin
            s2_valid_ff <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_touched_ff <= full;
         s1_avg_x_ff   <= full ? trim_x[TRIM_SHIFT +: ADC_BITS] : '0;
         s1_avg_y_ff   <= full ? trim_y[TRIM_SHIFT +: ADC_BITS] : '0;
      end
      if (load_s2) begin
         s2_touched_ff <= s1_touched_ff;
         s2_avg_x_ff   <= s1_avg_x_ff;
         s2_avg_y_ff   <= s1_avg_y_ff;
      end
      if (load_out) begin
         out_touched_ff <= s2_touched_ff;
         out_avg_x_ff   <= s2_avg_x_ff;
         out_avg_y_ff   <= s2_avg_y_ff;
      end
   end

   assign ctl_x = '{load_prod: load_s2, load_out: load_out, touched: s2_touched_ff};
   assign ctl_y = ctl_x;

   ttmc_calib #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_calib_x (
      .clock  (clock),
      .ctl    (ctl_x),
      .gain_a (regs_ff[REG_GAIN_X_FROM_X]),
      .gain_b (regs_ff[REG_GAIN_X_FROM_Y]),
      .offset (regs_ff[REG_OFFSET_X]),
      .avg_a  (s1_avg_x_ff),
      .avg_b  (s1_avg_y_ff),
      .disp   (disp_x)
   );

   ttmc_calib #(
      .ADC_BITS  (ADC_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_calib_y (
      .clock  (clock),
      .ctl    (ctl_y),
      .gain_a (regs_ff[REG_GAIN_Y_FROM_X]),
      .gain_b (regs_ff[REG_GAIN_Y_FROM_Y]),
      .offset (regs_ff[REG_OFFSET_Y]),
      .avg_a  (s1_avg_x_ff),
      .avg_b  (s1_avg_y_ff),
      .disp   (disp_y)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_touched_ff;
   assign rsp_tdata  = OUT_W'({disp_y, disp_x, out_avg_y_ff, out_avg_x_ff});

   logic unused_in;
   logic unused_pay;
   assign unused_in  = ^req_tdata[IN_W-1:2*ADC_BITS];
   assign unused_pay = (PAY_W > OUT_W);

endmodule
